FILE: design/gipc_pkg.sv
// Shared constants and types for the I/NAV page checker.
`default_nettype none

package gipc_pkg;

   localparam int unsigned PageBytes   = 29;
   localparam int unsigned PartBits    = 114;
   localparam int unsigned CrcDataBits = 196;
   localparam int unsigned CrcEndBit   = 220;
   localparam int unsigned WordBits    = 128;
   localparam int unsigned CrcBits     = 24;
   localparam int unsigned MaxWordType = 6;
   localparam int unsigned RspBits     = 144;

   localparam logic [CrcBits-1:0] CrcPoly   = 24'h864CFB;
   localparam logic [3:0]         FlagsGood = 4'b0010;

   typedef enum logic [2:0] {
      FailNone  = 3'd0,
      FailShort = 3'd1,
      FailFlags = 3'd2,
      FailCrc   = 3'd3,
      FailType  = 3'd4
   } gipc_fail_type;

   typedef struct packed {
      logic                accepted;
      gipc_fail_type       fail_reason;
      logic [5:0]          word_kind;
      logic [WordBits-1:0] word;
   } gipc_verdict_type;

endpackage

`default_nettype wire

FILE: design/galileo_inav_page_check_compact.sv
// Top level of the Galileo I/NAV page checker with CRC-24Q and compact word output.
// The result is registered and appears in the cycle after the byte marked last is taken.
// One byte is taken per cycle while no held result stalls the input; the byte update and verdict are combinational.
// A held result that the receiver does not take stalls the input until it is taken.
// Reset (synchronous, active high) clears the page state and the result valid.
`default_nettype none

module galileo_inav_page_check_compact import gipc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] data_byte
   input  wire logic               req_tlast,   // last_byte
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   // [0] accepted, [3:1] fail_reason, [9:4] word_kind, [73:10] word_high,
   // [137:74] word_low, [143:138] zero
   output      logic [RspBits-1:0] rsp_tdata
);

   logic             take;
   gipc_verdict_type verdict;

   logic                rsp_valid_ff;
   logic                accepted_ff;
   gipc_fail_type       reason_ff;
   logic [5:0]          type_ff;
   logic [WordBits-1:0] word_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   gipc_page_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .verdict   (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_tlast) begin
         accepted_ff <= verdict.accepted;
         reason_ff   <= verdict.fail_reason;
         type_ff     <= verdict.word_kind;
         word_ff     <= verdict.word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, word_ff[63:0], word_ff[127:64], type_ff, reason_ff, accepted_ff};

endmodule

`default_nettype wire

FILE: design/gipc_page_acc.sv
// Page accumulator: per-byte CRC, flag capture, compact word build and verdict.
`default_nettype none

module gipc_page_acc import gipc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [7:0]       data_byte,
   input  wire logic             last_byte,
   output gipc_verdict_type      verdict
);

   logic [4:0]          count_ff, count_in;
   logic [CrcBits-1:0]  crc_ff, crc_in;
   logic [CrcBits-1:0]  rcv_ff, rcv_in;
   logic [3:0]          flags_ff, flags_in;
   logic [WordBits-1:0] word_ff, word_in;

   logic [7:0] pos;
   logic [7:0] idx;
   logic       bit_v;
   logic       fb;
   logic [5:0] wtype;

   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      rcv_in   = rcv_ff;
      flags_in = flags_ff;
      word_in  = word_ff;
      pos      = '0;
      idx      = '0;
      bit_v    = 1'b0;
      fb       = 1'b0;
      if (count_ff < 5'(PageBytes)) begin
         for (int b = 0; b < 8; b++) begin
            pos   = {count_ff, 3'(b)};
            bit_v = data_byte[7 - b];
            if (pos < 8'(CrcDataBits)) begin
               fb     = crc_in[CrcBits-1] ^ bit_v;
               crc_in = {crc_in[CrcBits-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
            end else if (pos < 8'(CrcEndBit)) begin
               rcv_in = {rcv_in[CrcBits-2:0], bit_v};
            end
            if (pos == 8'd0) begin
               flags_in[3] = bit_v;
            end else if (pos == 8'd1) begin
               flags_in[2] = bit_v;
            end else if (pos == 8'(PartBits)) begin
               flags_in[1] = bit_v;
            end else if (pos == 8'(PartBits + 1)) begin
               flags_in[0] = bit_v;
            end
            if (pos >= 8'd2 && pos < 8'(PartBits)) begin
               idx = 8'(WordBits + 1) - pos;
               if (bit_v) begin
                  word_in[idx[6:0]] = 1'b1;
               end
            end else if (pos >= 8'(PartBits + 2) && pos < 8'(PartBits + 18)) begin
               idx = 8'(WordBits + 3) - pos;
               if (bit_v) begin
                  word_in[idx[6:0]] = 1'b1;
               end
            end
         end
         count_in = count_ff + 5'd1;
      end
   end

   assign wtype = word_in[WordBits-1 -: 6];

   always_comb begin
      verdict = '0;
      if (count_in < 5'(PageBytes)) begin
         verdict.fail_reason = FailShort;
      end else if (flags_in != FlagsGood) begin
         verdict.fail_reason = FailFlags;
      end else if (crc_in != rcv_in) begin
         verdict.fail_reason = FailCrc;
      end else if (wtype > 6'(MaxWordType)) begin
         verdict.fail_reason = FailType;
      end else begin
         verdict.accepted    = 1'b1;
         verdict.fail_reason = FailNone;
         verdict.word_kind   = wtype;
         verdict.word        = word_in;
      end
   end

   // clear the page after its result
   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         count_ff <= '0;
         crc_ff   <= '0;
         rcv_ff   <= '0;
         flags_ff <= '0;
         word_ff  <= '0;
      end else if (take) begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         rcv_ff   <= rcv_in;
         flags_ff <= flags_in;
         word_ff  <= word_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/gipc_checker.sv
// Port-level assertions for the I/NAV page checker, bound to the top level.
`default_nettype none

module gipc_checker import gipc_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tvalid,
   input wire logic               req_tready,
   input wire logic               req_tlast,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [RspBits-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_ok_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[3:1] == FailNone)
      else $error("accepted page with a fail reason");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[3:1] != FailNone && rsp_tdata[137:4] == '0)
      else $error("failed page with payload or no reason");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && (!rsp_tvalid || rsp_tready) |=> !rsp_tvalid)
      else $error("result without a last byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind galileo_inav_page_check_compact gipc_checker u_gipc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
